// File: sv/ordered_list_table_macros.svh
// Assertion macros shared by the list table modules.
// Each check is sampled on the rising edge of clk and is held off while rst_n is low.
`ifndef ORDERED_LIST_TABLE_MACROS_SVH
`define ORDERED_LIST_TABLE_MACROS_SVH

`ifndef SYNTHESIS
`define OLT_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define OLT_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);
`else
`define OLT_ASSERT(label, cond, msg)
`define OLT_ASSERT_NEXT(label, trig, cond, msg)
`endif

`endif

// File: sv/olt_pkg.sv
package olt_pkg;

    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int FOUND_W = 6;
    localparam int COUNT_W = 7;

    typedef enum logic [2:0] {
        REQ_APPEND       = 3'd0,
        REQ_INSERT       = 3'd1,
        REQ_REMOVE_VALUE = 3'd2,
        REQ_REMOVE_AT    = 3'd3,
        REQ_READ         = 3'd4,
        REQ_FIND         = 3'd5,
        REQ_CLEAR        = 3'd6
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_BAD_INDEX = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_MOVE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] item_value;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] read_value;
        logic [FOUND_W-1:0] found_position;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

endpackage

// File: sv/olt_ram.sv
module olt_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/olt_seq.sv
`include "ordered_list_table_macros.svh"

module olt_seq #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32,
    parameter int AW         = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  olt_pkg::request_t     req,
    output logic                  res_valid,
    input  logic                  res_take,
    output olt_pkg::result_t      res,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [ITEM_WIDTH-1:0] ram_wdata,
    output logic [AW-1:0]         ram_raddr,
    input  logic [ITEM_WIDTH-1:0] ram_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > olt_pkg::POS_W) ? CW : olt_pkg::POS_W;
    localparam int IW = (ITEM_WIDTH > olt_pkg::VALUE_W) ? ITEM_WIDTH : olt_pkg::VALUE_W;

    olt_pkg::state_t    state_reg, state_next;
    olt_pkg::req_kind_t kind_reg, kind_next;
    olt_pkg::status_t   status_reg, status_next;
    logic [ITEM_WIDTH-1:0]       w_reg, w_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               ptr_reg, ptr_next;
    logic [CW-1:0]               last_reg, last_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [AW-1:0]               wa_reg, wa_next;
    logic                        up_reg, up_next;
    logic                        rd_on_reg, rd_on_next;
    logic                        pend_reg, pend_next;
    logic [olt_pkg::VALUE_W-1:0] rd_reg, rd_next;
    logic [olt_pkg::FOUND_W-1:0] found_reg, found_next;

    logic [XW-1:0]         pos_x;
    logic [XW-1:0]         cnt_x;
    logic [XW-1:0]         idx_x;
    logic [CW-1:0]         pos_c;
    logic [CW-1:0]         last_cnt;
    logic [CW-1:0]         ptr_inc;
    logic [CW-1:0]         ptr_dec;
    logic [IW-1:0]         item_x;
    logic [IW-1:0]         rdata_x;
    logic [ITEM_WIDTH-1:0] w_in;
    logic                  full;
    logic                  match;
    logic                  go_read;
    logic                  go_scan;
    logic                  go_move;
    logic                  go_done;

    assign pos_x    = XW'(req.position);
    assign cnt_x    = XW'(count_reg);
    assign idx_x    = XW'(idx_reg);
    assign pos_c    = pos_x[CW-1:0];
    assign last_cnt = count_reg - CW'(1);
    assign ptr_inc  = ptr_reg + CW'(1);
    assign ptr_dec  = ptr_reg - CW'(1);
    assign item_x   = IW'(req.item_value);
    assign rdata_x  = IW'(ram_rdata);
    assign w_in     = item_x[ITEM_WIDTH-1:0];
    assign full     = (count_reg == CW'(CAPACITY));
    // The single comparator is shared by find and remove by value.
    assign match    = (ram_rdata == w_reg);

    // Datapath and memory control.
    always_comb
    begin
        kind_next   = kind_reg;
        status_next = status_reg;
        w_next      = w_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        idx_next    = idx_reg;
        wa_next     = wa_reg;
        up_next     = up_reg;
        rd_on_next  = rd_on_reg;
        pend_next   = pend_reg;
        rd_next     = rd_reg;
        found_next  = found_reg;
        ram_we      = 1'b0;
        ram_waddr   = wa_reg;
        ram_wdata   = ram_rdata;
        ram_raddr   = ptr_reg[AW-1:0];
        go_read     = 1'b0;
        go_scan     = 1'b0;
        go_move     = 1'b0;
        go_done     = 1'b0;

        unique case (state_reg)
            olt_pkg::S_IDLE:
            begin
                ram_raddr = pos_c[AW-1:0];
                if (req_valid)
                begin
                    kind_next   = olt_pkg::req_kind_t'(req.req_type);
                    w_next      = w_in;
                    status_next = olt_pkg::STAT_OK;
                    rd_next     = '0;
                    found_next  = '0;
                    pend_next   = 1'b0;
                    unique case (olt_pkg::req_kind_t'(req.req_type)) inside
                        olt_pkg::REQ_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = olt_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = w_in;
                                count_next = count_reg + CW'(1);
                            end
                            go_done = 1'b1;
                        end
                        olt_pkg::REQ_INSERT:
                        begin
                            if (pos_x > cnt_x)
                            begin
                                status_next = olt_pkg::STAT_BAD_INDEX;
                                go_done     = 1'b1;
                            end
                            else if (full)
                            begin
                                status_next = olt_pkg::STAT_FULL;
                                go_done     = 1'b1;
                            end
                            else if (pos_x == cnt_x)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = w_in;
                                count_next = count_reg + CW'(1);
                                go_done    = 1'b1;
                            end
                            else
                            begin
                                // Walk down from the last entry, moving each one up a place.
                                ptr_next   = last_cnt;
                                last_next  = pos_c;
                                up_next    = 1'b1;
                                rd_on_next = 1'b1;
                                go_move    = 1'b1;
                            end
                        end
                        olt_pkg::REQ_REMOVE_AT:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = olt_pkg::STAT_BAD_INDEX;
                                go_done     = 1'b1;
                            end
                            else if (pos_x == cnt_x - XW'(1))
                            begin
                                count_next = last_cnt;
                                go_done    = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = pos_c + CW'(1);
                                last_next  = last_cnt;
                                up_next    = 1'b0;
                                rd_on_next = 1'b1;
                                go_move    = 1'b1;
                            end
                        end
                        olt_pkg::REQ_READ:
                        begin
                            if (pos_x >= cnt_x)
                            begin
                                status_next = olt_pkg::STAT_BAD_INDEX;
                                go_done     = 1'b1;
                            end
                            else
                            begin
                                go_read = 1'b1;
                            end
                        end
                        olt_pkg::REQ_FIND, olt_pkg::REQ_REMOVE_VALUE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = olt_pkg::STAT_NOT_FOUND;
                                go_done     = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                rd_on_next = 1'b1;
                                go_scan    = 1'b1;
                            end
                        end
                        olt_pkg::REQ_CLEAR:
                        begin
                            count_next = '0;
                            go_done    = 1'b1;
                        end
                        default:
                        begin
                            go_done = 1'b1;
                        end
                    endcase
                end
            end
            olt_pkg::S_READ:
            begin
                rd_next = rdata_x[olt_pkg::VALUE_W-1:0];
                go_done = 1'b1;
            end
            olt_pkg::S_SCAN:
            begin
                // One read is issued per cycle; its word is compared in the next cycle.
                if (rd_on_reg)
                begin
                    pend_next = 1'b1;
                    idx_next  = ptr_reg;
                    ptr_next  = ptr_inc;
                    if (ptr_reg == last_cnt)
                    begin
                        rd_on_next = 1'b0;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (match)
                    begin
                        if (kind_reg == olt_pkg::REQ_FIND)
                        begin
                            found_next = idx_x[olt_pkg::FOUND_W-1:0];
                            go_done    = 1'b1;
                        end
                        else if (idx_reg == last_cnt)
                        begin
                            count_next = last_cnt;
                            go_done    = 1'b1;
                        end
                        else
                        begin
                            ptr_next   = idx_reg + CW'(1);
                            last_next  = last_cnt;
                            up_next    = 1'b0;
                            rd_on_next = 1'b1;
                            pend_next  = 1'b0;
                            go_move    = 1'b1;
                        end
                    end
                    else if (idx_reg == last_cnt)
                    begin
                        status_next = olt_pkg::STAT_NOT_FOUND;
                        go_done     = 1'b1;
                    end
                end
            end
            olt_pkg::S_MOVE:
            begin
                // Read one entry per cycle and write it one place over on the next.
                if (rd_on_reg)
                begin
                    pend_next = 1'b1;
                    wa_next   = up_reg ? ptr_inc[AW-1:0] : ptr_dec[AW-1:0];
                    ptr_next  = up_reg ? ptr_dec : ptr_inc;
                    if (ptr_reg == last_reg)
                    begin
                        rd_on_next = 1'b0;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wa_reg;
                    ram_wdata = ram_rdata;
                end
                else if (!rd_on_reg)
                begin
                    if (up_reg)
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = last_reg[AW-1:0];
                        ram_wdata  = w_reg;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = last_cnt;
                    end
                    go_done = 1'b1;
                end
            end
            olt_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            olt_pkg::S_IDLE:
            begin
                if (go_read)
                begin
                    state_next = olt_pkg::S_READ;
                end
                else if (go_scan)
                begin
                    state_next = olt_pkg::S_SCAN;
                end
                else if (go_move)
                begin
                    state_next = olt_pkg::S_MOVE;
                end
                else if (go_done)
                begin
                    state_next = olt_pkg::S_DONE;
                end
            end
            olt_pkg::S_READ:
            begin
                state_next = olt_pkg::S_DONE;
            end
            olt_pkg::S_SCAN:
            begin
                if (go_move)
                begin
                    state_next = olt_pkg::S_MOVE;
                end
                else if (go_done)
                begin
                    state_next = olt_pkg::S_DONE;
                end
            end
            olt_pkg::S_MOVE:
            begin
                if (go_done)
                begin
                    state_next = olt_pkg::S_DONE;
                end
            end
            olt_pkg::S_DONE:
            begin
                if (res_take)
                begin
                    state_next = olt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready          = (state_reg == olt_pkg::S_IDLE);
        res_valid          = (state_reg == olt_pkg::S_DONE);
        res.status         = status_reg;
        res.read_value     = rd_reg;
        res.found_position = found_reg;
        res.entry_count    = cnt_x[olt_pkg::COUNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= olt_pkg::S_IDLE;
            count_reg <= '0;
            rd_on_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_on_reg <= rd_on_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        status_reg <= status_next;
        w_reg      <= w_next;
        ptr_reg    <= ptr_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        wa_reg     <= wa_next;
        up_reg     <= up_next;
        rd_reg     <= rd_next;
        found_reg  <= found_next;
    end

    `OLT_ASSERT(a_count_bound, count_reg <= CW'(CAPACITY), "entry count exceeds capacity")
    `OLT_ASSERT(a_waddr_range, !ram_we || (int'(ram_waddr) < CAPACITY), "write beyond capacity")
    `OLT_ASSERT(a_scan_nonempty, (state_reg != olt_pkg::S_SCAN) || (count_reg != '0), "empty scan")
    `OLT_ASSERT_NEXT(a_done_holds_count, state_reg == olt_pkg::S_DONE, $stable(count_reg), "count moved")

endmodule

// File: sv/ordered_list_table.sv
`include "ordered_list_table_macros.svh"

// Ordered list table: keeps up to CAPACITY words in order plus an entry count, and answers
// each request word with exactly one result word (status, word read, index found, new count).
// Requests are handled one at a time; s_tready is low while a request is being worked on.
// The entries sit in one memory with a single write port and a registered read port, and a
// sequencer walks it one entry per cycle, so the time from acceptance to a result depends on
// the request: append, clear and unused codes go straight to the result, read waits for one
// memory read, insert at position p moves each entry from the last down to p up a place,
// remove at position p moves each entry above p down a place, find reads from index 0 until
// the word matches or the list ends, and remove by value is a find followed by a remove at
// the found index. The result goes into an output register, so a new request can be taken
// while the previous result still waits for m_tready.
module ordered_list_table #(
    parameter int CAPACITY   = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[6:0], item_value[38:7], zero[39]
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // read_value[31:0], found_position[37:32],
                                   // entry_count[44:38], zero[47:45]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int AW = $clog2(CAPACITY);

    olt_pkg::request_t req;
    olt_pkg::result_t  res;
    olt_pkg::result_t  res_reg, res_next;
    logic              m_valid_reg, m_valid_next;
    logic              res_valid;
    logic              res_take;
    logic              req_ready;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [ITEM_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [ITEM_WIDTH-1:0] ram_rdata;

    assign req.req_type   = s_tuser;
    assign req.position   = s_tdata[6:0];
    assign req.item_value = s_tdata[38:7];

    olt_seq #(
        .CAPACITY   (CAPACITY),
        .ITEM_WIDTH (ITEM_WIDTH),
        .AW         (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    olt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ITEM_WIDTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The finished result moves into the output register once it is empty or being drained.
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_comb
    begin
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        if (res_take)
        begin
            res_next     = res;
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign s_tready = req_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {3'b000, res_reg.entry_count, res_reg.found_position, res_reg.read_value};

    `OLT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "took two words at once")

endmodule
